### rtl/kmst_pkg.sv
package kmst_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;

    localparam int VtxW   = 7;
    localparam int WgtW   = 16;
    localparam int SumW   = 22;
    localparam int NodeAw = $clog2(MaxNodes);
    localparam int EdgeAw = $clog2(MaxEdges);
    localparam int TotW   = EdgeAw + 1;
    localparam int CountW = NodeAw;
    localparam int KeyW   = WgtW + EdgeAw;

    localparam logic ActLoad    = 1'b0;
    localparam logic ActCompute = 1'b1;

    // one stored edge
    typedef struct packed {
        logic [WgtW-1:0] weight;
        logic [VtxW-1:0] to;
        logic [VtxW-1:0] from;
    } t_edge;

    // one result record
    typedef struct packed {
        logic            last;
        logic            overflow;
        logic            spanning;
        logic            edge_valid;
        logic [SumW-1:0] total;
        logic [WgtW-1:0] weight;
        logic [VtxW-1:0] to;
        logic [VtxW-1:0] from;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic clr_step;
        logic scan_init;
        logic scan_step;
        logic take_best;
        logic set_a;
        logic set_b;
        logic walk;
        logic latch_ru;
        logic latch_rv;
        logic union_op;
        logic push;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic best_found;
        logic at_root;
        logic roots_same;
        logic full;
        logic out_free;
    } t_sts;

endpackage

### rtl/kruskal_minimum_spanning_tree_core.sv
// Channel   Dir  Payload                                       Side band
// s_axis    in   tdata: edge_from, edge_to, edge_weight        tuser: action
// m_axis    out  tdata: tree_from, tree_to, tree_weight, total tuser: flags; tlast: last
// cfg       in   i_cfg_wdata: vertex_count on i_cfg_we         none
//
// Loads are accepted back to back while the core is idle.
// A compute run first clears the parent memory, then for every edge examined in
// weight order makes one scan of the edge memory and two root walks, one from
// each end of the edge.
// Reset is synchronous and active low; the edge memory needs no clearing.
// A stalled m_axis holds the run until the output register drains.
module kruskal_minimum_spanning_tree_core import kmst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // edge_from[6:0], edge_to[13:7], edge_weight[29:14]
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // tree_from[6:0], tree_to[13:7], tree_weight[29:14],
                                       // total_weight[51:30]
    output logic [2:0]  m_axis_tuser,  // edge_valid[0], spanning[1], overflow[2]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    t_cmd  w_cmd;
    t_sts  w_sts;
    t_edge w_edge;
    t_res  w_res;

    // unpack the input transaction
    assign w_edge.from   = s_axis_tdata[6:0];
    assign w_edge.to     = s_axis_tdata[13:7];
    assign w_edge.weight = s_axis_tdata[29:14];

    kmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    kmst_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_edge      (w_edge),
        .o_res       (w_res),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready)
    );

    // pack the output transaction
    assign m_axis_tdata = {4'd0, w_res.total, w_res.weight, w_res.to, w_res.from};
    assign m_axis_tuser = {w_res.overflow, w_res.spanning, w_res.edge_valid};
    assign m_axis_tlast = w_res.last;

endmodule

### rtl/kmst_ctrl.sv
module kmst_ctrl import kmst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_action,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StClr   = 4'd1;
    localparam logic [3:0] StSInit = 4'd2;
    localparam logic [3:0] StScan  = 4'd3;
    localparam logic [3:0] StFaRd  = 4'd4;
    localparam logic [3:0] StFaChk = 4'd5;
    localparam logic [3:0] StFbRd  = 4'd6;
    localparam logic [3:0] StFbChk = 4'd7;
    localparam logic [3:0] StUnion = 4'd8;
    localparam logic [3:0] StPush  = 4'd9;
    localparam logic [3:0] StFin   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == StIdle);
    assign w_acc      = o_in_ready && i_in_valid;

    // accept loads and sequence one compute run
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            StIdle: begin
                if (w_acc && i_in_action == ActLoad) begin
                    o_cmd.load = 1'b1;
                end
                if (w_acc && i_in_action == ActCompute) begin
                    o_cmd.start = 1'b1;
                    n_state     = StClr;
                end
            end
            StClr: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = StSInit;
                end
            end
            StSInit: begin
                o_cmd.scan_init = 1'b1;
                n_state = i_sts.full ? StFin : StScan;
            end
            StScan: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.best_found) begin
                        o_cmd.take_best = 1'b1;
                        o_cmd.set_a     = 1'b1;
                        n_state         = StFaRd;
                    end else begin
                        n_state = StFin;
                    end
                end
            end
            StFaRd: n_state = StFaChk;
            StFaChk: begin
                if (i_sts.at_root) begin
                    o_cmd.latch_ru = 1'b1;
                    o_cmd.set_b    = 1'b1;
                    n_state        = StFbRd;
                end else begin
                    o_cmd.walk = 1'b1;
                    n_state    = StFaRd;
                end
            end
            StFbRd: n_state = StFbChk;
            StFbChk: begin
                if (i_sts.at_root) begin
                    o_cmd.latch_rv = 1'b1;
                    n_state        = StUnion;
                end else begin
                    o_cmd.walk = 1'b1;
                    n_state    = StFbRd;
                end
            end
            StUnion: begin
                if (i_sts.roots_same) begin
                    n_state = StSInit;
                end else begin
                    o_cmd.union_op = 1'b1;
                    n_state        = StPush;
                end
            end
            StPush: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.full ? StFin : StSInit;
                end
            end
            StFin: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

    // a run command never coincides with a load
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.start)) else $error("load and start together");
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !o_in_ready) else $error("ready during run");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_in_ready) else $error("not idle after finish");

endmodule

### rtl/kmst_datapath.sv
module kmst_datapath import kmst_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    input  logic            i_cfg_we,
    input  logic [VtxW-1:0] i_cfg_wdata,
    input  t_edge           i_edge,
    output t_res            o_res,
    output logic            o_res_valid,
    input  logic            i_res_ready
);

    // storage
    t_edge             r_edge_mem [MaxEdges];
    logic [NodeAw-1:0] r_par_mem  [MaxNodes];

    logic [VtxW-1:0]   r_vcount;
    logic [TotW-1:0]   r_edge_total;
    logic              r_ovf;
    logic [NodeAw-1:0] r_clr;

    // scan state
    logic [TotW-1:0]   r_idx;
    logic              r_rd_v;
    logic [EdgeAw-1:0] r_rd_idx;
    t_edge             r_edge_rd;
    logic              r_have_prev;
    logic [KeyW-1:0]   r_prev_key;
    logic              r_best_found;
    logic [KeyW-1:0]   r_best_key;
    t_edge             r_best;

    // union-find state
    logic [NodeAw-1:0] r_node, r_par_rd, r_ru, r_rv;
    logic [CountW-1:0] r_count;
    logic [SumW-1:0]   r_sum;
    t_res              r_new, r_pend, r_out;
    logic              r_pend_v, r_out_valid;

    logic [VtxW-1:0]   w_n;
    logic              w_in_ok, w_cand_ok, w_better;
    logic [KeyW-1:0]   w_cand_key;
    logic [SumW-1:0]   w_sum_next;
    t_res              w_pend_out, w_fin_out;

    // effective vertex count
    always_comb begin
        if (r_vcount == '0) begin
            w_n = VtxW'(1);
        end else if (r_vcount > VtxW'(MaxNodes)) begin
            w_n = VtxW'(MaxNodes);
        end else begin
            w_n = r_vcount;
        end
    end

    assign w_in_ok = (i_edge.from != '0) && (i_edge.from <= w_n) &&
                     (i_edge.to != '0) && (i_edge.to <= w_n);
    assign w_cand_ok = (r_edge_rd.from != '0) && (r_edge_rd.from <= w_n) &&
                       (r_edge_rd.to != '0) && (r_edge_rd.to <= w_n);
    assign w_cand_key = {r_edge_rd.weight, r_rd_idx};
    assign w_better = w_cand_ok && (!r_have_prev || w_cand_key > r_prev_key) &&
                      (!r_best_found || w_cand_key < r_best_key);
    assign w_sum_next = r_sum + SumW'(r_best.weight);

    assign o_sts.clr_done   = (r_clr == NodeAw'(MaxNodes - 1));
    assign o_sts.scan_done  = (r_idx >= r_edge_total) && !r_rd_v;
    assign o_sts.best_found = r_best_found;
    assign o_sts.at_root    = (r_par_rd == r_node);
    assign o_sts.roots_same = (r_ru == r_rv);
    assign o_sts.full       = ((VtxW'(r_count) + VtxW'(1)) == w_n);
    assign o_sts.out_free   = !r_out_valid || i_res_ready;

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    // next output record: held edge, or the closing record of the run
    always_comb begin
        w_pend_out          = r_pend;
        w_pend_out.overflow = r_ovf;
        w_fin_out           = r_pend_v ? r_pend : '0;
        w_fin_out.spanning  = o_sts.full;
        w_fin_out.overflow  = r_ovf;
        w_fin_out.last      = 1'b1;
    end

    // edge memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_ok && r_edge_total < TotW'(MaxEdges)) begin
            r_edge_mem[r_edge_total[EdgeAw-1:0]] <= i_edge;
        end
        r_edge_rd <= r_edge_mem[r_idx[EdgeAw-1:0]];
        r_rd_idx  <= r_idx[EdgeAw-1:0];
    end

    // parent memory: clear sweep or merge write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_par_mem[r_clr] <= r_clr;
        end else if (i_cmd.union_op) begin
            r_par_mem[r_rv] <= r_ru;
        end
        r_par_rd <= r_par_mem[r_node];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount     <= VtxW'(MaxNodes);
            r_edge_total <= '0;
            r_ovf        <= 1'b0;
            r_rd_v       <= 1'b0;
            r_pend_v     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_sum        <= '0;
            r_best_found <= 1'b0;
            r_have_prev  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            // store a valid load, or flag it dropped when the edge memory is full
            if (i_cmd.load && w_in_ok) begin
                if (r_edge_total < TotW'(MaxEdges)) begin
                    r_edge_total <= r_edge_total + TotW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_count     <= '0;
                r_sum       <= '0;
                r_pend_v    <= 1'b0;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_rd_v       <= 1'b0;
                r_best_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_rd_v <= (r_idx < r_edge_total);
                if (r_rd_v && w_better) begin
                    r_best_found <= 1'b1;
                end
            end
            if (i_cmd.take_best) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.union_op) begin
                r_count <= r_count + CountW'(1);
                r_sum   <= w_sum_next;
            end
            // hand results to the output register
            if ((i_cmd.push && r_pend_v) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_pend_v     <= 1'b0;
                r_edge_total <= '0;
                r_ovf        <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + NodeAw'(1);
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step && r_idx < r_edge_total) begin
            r_idx <= r_idx + TotW'(1);
        end
        if (i_cmd.scan_step && r_rd_v && w_better) begin
            r_best_key <= w_cand_key;
            r_best     <= r_edge_rd;
        end
        if (i_cmd.take_best) begin
            r_prev_key <= r_best_key;
        end
        // walk toward the set root
        if (i_cmd.set_a) begin
            r_node <= NodeAw'(r_best.from - VtxW'(1));
        end else if (i_cmd.set_b) begin
            r_node <= NodeAw'(r_best.to - VtxW'(1));
        end else if (i_cmd.walk) begin
            r_node <= r_par_rd;
        end
        if (i_cmd.latch_ru) begin
            r_ru <= r_node;
        end
        if (i_cmd.latch_rv) begin
            r_rv <= r_node;
        end
        if (i_cmd.union_op) begin
            r_new.from       <= r_best.from;
            r_new.to         <= r_best.to;
            r_new.weight     <= r_best.weight;
            r_new.total      <= w_sum_next;
            r_new.edge_valid <= 1'b1;
            r_new.spanning   <= 1'b0;
            r_new.overflow   <= 1'b0;
            r_new.last       <= 1'b0;
        end
        if (i_cmd.push) begin
            r_pend <= r_new;
            if (r_pend_v) begin
                r_out <= w_pend_out;
            end
        end
        // close the run: held edge or the empty result
        if (i_cmd.finish) begin
            r_out <= w_fin_out;
        end
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= TotW'(MaxEdges)) else $error("edge count past capacity");
    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.union_op |-> r_ru != r_rv) else $error("merge of one set");
    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_count != '0) else $error("held edge without count");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push || i_cmd.finish) |-> o_sts.out_free) else $error("output overrun");

endmodule
